// ===== rtl/pfa_pkg.sv =====
// Shared types and constants of the partition fit allocator.
// Used by the cell row and the top level; depends on nothing else.
package pfa_pkg;

    // Widths fixed by the item format.
    localparam int TOTAL_W    = 24;
    localparam int REQ_W      = 2;
    localparam int BIDX_W     = 6;
    localparam int RSIZE_W    = 16;
    localparam int POLICY_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    // Wide enough to name a block of the largest table the design supports.
    localparam int CMD_IDX_W  = 8;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Item kinds.
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Fit policies; the unused code behaves as first fit.
    localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic                 load;
        logic                 clear;
        logic                 commit;
        logic                 var_mode;
        logic [POLICY_W-1:0]  policy;
        logic [COUNT_W-1:0]   count;
        logic [BIDX_W-1:0]    load_idx;
        logic [CMD_IDX_W-1:0] commit_idx;
    } pfa_ctrl_t;

endpackage

// ===== rtl/pfa_cell.sv =====
// One table cell: holds a block size and its used mark, and refines the
// passing search token. Depends on pfa_pkg.
module pfa_cell #(
    parameter int SIZE_WIDTH = 16,
    parameter int IDX_W      = 6,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pfa_pkg::pfa_ctrl_t    ctrl,
    input  logic [SIZE_WIDTH-1:0] data,
    input  logic                  tok_found_i,
    input  logic [IDX_W-1:0]      tok_idx_i,
    input  logic [SIZE_WIDTH-1:0] tok_size_i,
    output logic                  tok_found_o,
    output logic [IDX_W-1:0]      tok_idx_o,
    output logic [SIZE_WIDTH-1:0] tok_size_o
);
    import pfa_pkg::*;

    logic [SIZE_WIDTH-1:0] size_reg;
    logic                  used_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [SIZE_WIDTH-1:0] tsize_reg;
    logic                  fits;
    logic                  take;

    // A cell beyond the block count, or a used block in fixed mode, never fits.
    assign fits = (INDEX < int'(ctrl.count)) && !(!ctrl.var_mode && used_reg)
                  && (size_reg >= data);

    always_comb begin
        case (ctrl.policy)
            FIT_BEST:  take = fits && (!tok_found_i || size_reg < tok_size_i);
            FIT_WORST: take = fits && (!tok_found_i || size_reg > tok_size_i);
            default:   take = fits && !tok_found_i;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            idx_reg   <= IDX_W'(INDEX);
            tsize_reg <= size_reg;
        end else begin
            idx_reg   <= tok_idx_i;
            tsize_reg <= tok_size_i;
        end
        found_reg <= tok_found_i || take;
        if (ctrl.load && int'(ctrl.load_idx) == INDEX) begin
            size_reg <= data;
        end else if (ctrl.commit && ctrl.var_mode && int'(ctrl.commit_idx) == INDEX) begin
            size_reg <= size_reg - data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else if (ctrl.clear || (ctrl.load && int'(ctrl.load_idx) == INDEX)) begin
            used_reg <= 1'b0;
        end else if (ctrl.commit && !ctrl.var_mode && int'(ctrl.commit_idx) == INDEX) begin
            used_reg <= 1'b1;
        end
    end

    assign tok_found_o = found_reg;
    assign tok_idx_o   = idx_reg;
    assign tok_size_o  = tsize_reg;

endmodule

// ===== rtl/partition_fit_allocator.sv =====
// Top level of the partition fit allocator: controller, totals and the row
// of pfa_cell instances. Depends on pfa_pkg and pfa_cell.
//
// The block table lives in a row of MAX_BLOCKS cells, one block size and used
// mark per cell. A search token enters the first cell every cycle and moves one
// cell per cycle, each cell replacing the token's candidate when its own block
// fits better under the configured policy; ties keep the lower index because
// only a strictly better block replaces the candidate. An allocate beat is
// decoded in the execute state, lets the token walk down the cell row in the
// scan state, and in the done state commits the choice, updates the totals
// and registers its result. The next beat is accepted only once the controller
// is back in idle, so allocate beats never overlap in the cell row, and the
// done state stretches for as long as an earlier result still waits.
// Load, clear and unknown beats give no result and pass through the execute
// state only, without a scan. The input
// is accepted while an earlier result still waits on the output; a new result
// is held back until that one has been taken. Block sizes are not reset and
// need no clearing pass: a block must be loaded before any search reaches it.
// Configuration writes are always accepted and are meant to happen while the
// block is idle.
module partition_fit_allocator #(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pfa_pkg::REQ_W-1:0]       s_req_type,
    input  logic [pfa_pkg::BIDX_W-1:0]      s_block_index,
    input  logic [pfa_pkg::RSIZE_W-1:0]     s_request_size,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_allocated,
    output logic [pfa_pkg::BIDX_W-1:0]      m_chosen_block,
    output logic [pfa_pkg::TOTAL_W-1:0]     m_internal_total,
    output logic [pfa_pkg::TOTAL_W-1:0]     m_external_total,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pfa_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = IDX_W;
    localparam int SUM_W = ((SIZE_WIDTH > TOTAL_W) ? SIZE_WIDTH : TOTAL_W) + 1;

    // Controller states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      scan_cnt_reg;
    logic [REQ_W-1:0]      kind_reg;
    logic [BIDX_W-1:0]     bidx_reg;
    logic [SIZE_WIDTH-1:0] size_reg;

    logic [POLICY_W-1:0]   policy_reg;
    logic                  mode_reg;
    logic [COUNT_W-1:0]    count_reg;

    logic [TOTAL_W-1:0]    internal_reg;
    logic [TOTAL_W-1:0]    external_reg;

    logic                  m_valid_reg;
    logic                  alloc_reg;
    logic [BIDX_W-1:0]     chosen_reg;
    logic [TOTAL_W-1:0]    int_out_reg;
    logic [TOTAL_W-1:0]    ext_out_reg;

    logic                  s_fire;
    logic                  out_free;
    logic                  finish;
    pfa_ctrl_t             ctrl;
    logic [SIZE_WIDTH-1:0] leftover;
    logic [TOTAL_W-1:0]    internal_sat;
    logic [TOTAL_W-1:0]    external_sat;

    // Token links between cells; link 0 feeds the first cell an empty token.
    logic                  tok_found [MAX_BLOCKS+1];
    logic [IDX_W-1:0]      tok_idx   [MAX_BLOCKS+1];
    logic [SIZE_WIDTH-1:0] tok_size  [MAX_BLOCKS+1];

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] acc,
                                                   input logic [SIZE_WIDTH-1:0] add);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(acc) + SUM_W'(add);
        sat_add = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign finish    = (state_reg == ST_DONE) && out_free;

    // The table does not change while a search runs, so the token at the end
    // of the row stays correct for as long as the output is stalled.
    assign leftover     = tok_size[MAX_BLOCKS] - size_reg;
    assign internal_sat = sat_add(internal_reg, leftover);
    assign external_sat = sat_add(external_reg, size_reg);

    always_comb begin
        ctrl.load       = (state_reg == ST_EXEC) && (kind_reg == REQ_LOAD);
        ctrl.clear      = (state_reg == ST_EXEC) && (kind_reg == REQ_CLEAR);
        ctrl.commit     = finish && tok_found[MAX_BLOCKS];
        ctrl.var_mode   = mode_reg;
        ctrl.policy     = policy_reg;
        ctrl.count      = count_reg;
        ctrl.load_idx   = bidx_reg;
        ctrl.commit_idx = CMD_IDX_W'(tok_idx[MAX_BLOCKS]);
    end

    assign tok_found[0] = 1'b0;
    assign tok_idx[0]   = '0;
    assign tok_size[0]  = '0;

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        pfa_cell #(
            .SIZE_WIDTH (SIZE_WIDTH),
            .IDX_W      (IDX_W),
            .INDEX      (g)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .data        (size_reg),
            .tok_found_i (tok_found[g]),
            .tok_idx_i   (tok_idx[g]),
            .tok_size_i  (tok_size[g]),
            .tok_found_o (tok_found[g+1]),
            .tok_idx_o   (tok_idx[g+1]),
            .tok_size_o  (tok_size[g+1])
        );
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = (kind_reg == REQ_ALLOC) ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (scan_cnt_reg == CNT_W'(MAX_BLOCKS - 1)) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and totals.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            policy_reg   <= FIT_FIRST;
            mode_reg     <= 1'b0;
            count_reg    <= COUNT_W'(1);
            internal_reg <= '0;
            external_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SCAN) begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end else begin
                scan_cnt_reg <= '0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_POLICY: policy_reg <= cfg_data[POLICY_W-1:0];
                    CFG_MODE:   mode_reg   <= cfg_data[0];
                    CFG_COUNT:  count_reg  <= cfg_data[COUNT_W-1:0];
                    default:    ;
                endcase
            end
            if (ctrl.clear) begin
                internal_reg <= '0;
                external_reg <= '0;
            end else if (finish) begin
                if (!tok_found[MAX_BLOCKS]) begin
                    external_reg <= external_sat;
                end else if (!mode_reg) begin
                    internal_reg <= internal_sat;
                end
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture and the result register.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg <= s_req_type;
            bidx_reg <= s_block_index;
            size_reg <= SIZE_WIDTH'(s_request_size);
        end
        if (finish) begin
            alloc_reg   <= tok_found[MAX_BLOCKS];
            chosen_reg  <= tok_found[MAX_BLOCKS] ? BIDX_W'(tok_idx[MAX_BLOCKS]) : '0;
            int_out_reg <= (tok_found[MAX_BLOCKS] && !mode_reg) ? internal_sat
                                                                 : internal_reg;
            ext_out_reg <= tok_found[MAX_BLOCKS] ? external_reg : external_sat;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_allocated      = alloc_reg;
    assign m_chosen_block   = chosen_reg;
    assign m_internal_total = int_out_reg;
    assign m_external_total = ext_out_reg;

endmodule

// ===== rtl/pfa_checker.sv =====
// Port-level checks for the partition fit allocator, bound to its top level.
// Depends on pfa_pkg and on partition_fit_allocator.
module pfa_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [pfa_pkg::REQ_W-1:0]       s_req_type,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_allocated,
    input logic [pfa_pkg::BIDX_W-1:0]      m_chosen_block,
    input logic [pfa_pkg::TOTAL_W-1:0]     m_internal_total,
    input logic [pfa_pkg::TOTAL_W-1:0]     m_external_total
);
    import pfa_pkg::*;

    // Allocate beats taken in and not yet delivered.
    logic [1:0] pend_reg;
    logic       s_alloc;
    logic       m_fire;

    assign s_alloc = s_valid && s_ready && (s_req_type == REQ_ALLOC);
    assign m_fire  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
        end else begin
            pend_reg <= pend_reg + {1'b0, s_alloc} - {1'b0, m_fire};
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_allocated)
            && $stable(m_chosen_block) && $stable(m_internal_total)
            && $stable(m_external_total))
        else $error("result beat changed while stalled");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("result beat without an allocate beat");

    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == 2'd2 |-> !s_ready)
        else $error("input taken with two results outstanding");

    a_miss_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_allocated |-> m_chosen_block == '0)
        else $error("failed request reports a block");

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (.*);
